// ===== sv/rcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrc_pkg
// Shared types and constants for the configurable reflected CRC block.
// ----------------------------------------------------------------------------
package rcrc_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;
   localparam int CrcWidth      = 16;
   localparam int ByteWidth     = 8;

   localparam logic [CsrIndexWidth-1:0] REG_WIDTH_MODE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_POLY_SIXTEEN = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_INIT_SIXTEEN = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_POLY_EIGHT   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_INIT_EIGHT   = 3'd4;

   localparam logic        WIDTH_MODE_RESET   = 1'b1;
   localparam logic [15:0] POLY_SIXTEEN_RESET = 16'h1021;
   localparam logic [15:0] INIT_SIXTEEN_RESET = 16'hffff;
   localparam logic [7:0]  POLY_EIGHT_RESET   = 8'h31;
   localparam logic [7:0]  INIT_EIGHT_RESET   = 8'hff;

   typedef struct packed {
      logic        wide;
      logic [15:0] poly_sixteen;
      logic [15:0] init_sixteen;
      logic [7:0]  poly_eight;
      logic [7:0]  init_eight;
   } cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 byte_present;
      logic                 first_of_message;
      logic                 last_of_message;
   } item_type;

endpackage

// ===== sv/rcrc_csr.sv =====
// ----------------------------------------------------------------------------
// rcrc_csr
// Configuration registers: mode, polynomials and start values.
// ----------------------------------------------------------------------------
module rcrc_csr
   import rcrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_WIDTH_MODE:   cfg_in.wide         = csr_wdata[0];
            REG_POLY_SIXTEEN: cfg_in.poly_sixteen = csr_wdata;
            REG_INIT_SIXTEEN: cfg_in.init_sixteen = csr_wdata;
            REG_POLY_EIGHT:   cfg_in.poly_eight   = csr_wdata[7:0];
            REG_INIT_EIGHT:   cfg_in.init_eight   = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide         <= WIDTH_MODE_RESET;
         cfg_ff.poly_sixteen <= POLY_SIXTEEN_RESET;
         cfg_ff.init_sixteen <= INIT_SIXTEEN_RESET;
         cfg_ff.poly_eight   <= POLY_EIGHT_RESET;
         cfg_ff.init_eight   <= INIT_EIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/rcrc_fold.sv =====
// ----------------------------------------------------------------------------
// rcrc_fold
// One item's CRC update: restart, byte fold over eight shift steps, result.
// ----------------------------------------------------------------------------
module rcrc_fold
   import rcrc_pkg::*;
(
   input  cfg_type              cfg,
   input  item_type             item,
   input  logic [CrcWidth-1:0]  crc_cur,
   output logic [CrcWidth-1:0]  crc_next,
   output logic [CrcWidth-1:0]  crc_result
);

   logic [CrcWidth-1:0] start;
   logic [CrcWidth-1:0] rpoly;
   logic [CrcWidth-1:0] base;
   logic [CrcWidth-1:0] work;
   logic [CrcWidth-1:0] after_byte;

   assign start = cfg.wide ? cfg.init_sixteen : {8'h00, cfg.init_eight};

   always_comb begin
      rpoly = '0;
      if (cfg.wide) begin
         for (int i = 0; i < 16; i++) rpoly[i] = cfg.poly_sixteen[15-i];
      end else begin
         for (int i = 0; i < 8; i++) rpoly[i] = cfg.poly_eight[7-i];
      end
   end

   assign base = item.first_of_message ? start : crc_cur;

   always_comb begin
      work = cfg.wide ? base : {8'h00, base[7:0]};
      work = work ^ {8'h00, item.data_byte};
      for (int k = 0; k < 8; k++) begin
         work = work[0] ? ((work >> 1) ^ rpoly) : (work >> 1);
      end
      if (!cfg.wide) work = {8'h00, work[7:0]};
   end

   assign after_byte = item.byte_present ? work : base;
   assign crc_result = cfg.wide ? after_byte : {8'h00, after_byte[7:0]};
   assign crc_next   = item.last_of_message ? start : after_byte;

endmodule

// ===== sv/reflected_crc_8_16_configurable.sv =====
// ----------------------------------------------------------------------------
// reflected_crc_8_16_configurable
// Reflected CRC-8/CRC-16 over a byte stream, polynomial and start configurable.
// Path: a last word goes into the input register, then the fold logic updates
// the running CRC register, which closes the loop, and the result register.
// Throughput: one word per cycle, unless a last word waits on a held result.
// Reset: synchronous; clears the pipeline, sets CRC to the 16-bit start value.
// ----------------------------------------------------------------------------
module reflected_crc_8_16_configurable
   import rcrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ByteWidth-1:0]     req_data_byte,
   input  logic                     req_byte_present,
   input  logic                     req_first_of_message,
   input  logic                     req_last_of_message,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CrcWidth-1:0]      rsp_crc_value
);

   cfg_type             cfg;
   item_type            item_ff;
   logic                item_valid_ff;
   logic [CrcWidth-1:0] crc_ff;
   logic [CrcWidth-1:0] crc_in;
   logic [CrcWidth-1:0] crc_result;
   logic                rsp_valid_ff;
   logic [CrcWidth-1:0] rsp_crc_ff;
   logic                advance;
   logic                take;

   rcrc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   rcrc_fold u_fold (
      .cfg        (cfg),
      .item       (item_ff),
      .crc_cur    (crc_ff),
      .crc_next   (crc_in),
      .crc_result (crc_result)
   );

   // a last word needs the result slot free or draining
   assign advance   = item_valid_ff &&
                      (!item_ff.last_of_message || !rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         crc_ff        <= INIT_SIXTEEN_RESET;
      end else begin
         if (take) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            crc_ff <= crc_in;
         end
         if (advance && item_ff.last_of_message) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte        <= req_data_byte;
         item_ff.byte_present     <= req_byte_present;
         item_ff.first_of_message <= req_first_of_message;
         item_ff.last_of_message  <= req_last_of_message;
      end
      if (advance && item_ff.last_of_message) begin
         rsp_crc_ff <= crc_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

endmodule

// ===== sv/rcrc_checker.sv =====
// ----------------------------------------------------------------------------
// rcrc_checker
// Port-level checks on the CRC block, bound to the top level.
// ----------------------------------------------------------------------------
module rcrc_checker
   import rcrc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     csr_write_enable,
   input logic [CsrIndexWidth-1:0] csr_index,
   input logic [CsrDataWidth-1:0]  csr_wdata,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_last_of_message,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [CrcWidth-1:0]      rsp_crc_value
);

   logic cfg_narrow_write;
   assign cfg_narrow_write = csr_write_enable && (csr_index == REG_WIDTH_MODE) && !csr_wdata[0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crc_value))
      else $error("result word changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with result side free");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_of_message, 2))
      else $error("result without a last word two cycles earlier");

   a_narrow_write_seen: assert property (@(posedge clock) disable iff (reset)
      cfg_narrow_write |-> !$isunknown(csr_wdata))
      else $error("unknown data on mode write");

endmodule

bind reflected_crc_8_16_configurable rcrc_checker u_checker (.*);

// ===== tb/reflected_crc_8_16_configurable_crc_check.sv =====
// ----------------------------------------------------------------------------
// reflected_crc_8_16_configurable_crc_check
// Watches the CSR port and both word channels of the reflected CRC block. It
// keeps its own CRC register and settings, works out the CRC due on each word
// marked last, and compares every CRC word returned against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reflected_crc_8_16_configurable_crc_check
   import rcrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [ByteWidth-1:0]     req_data_byte,
   input  logic                     req_byte_present,
   input  logic                     req_first_of_message,
   input  logic                     req_last_of_message,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [CrcWidth-1:0]      rsp_crc_value,
   output int                       fail_count,
   output int                       pending_crcs,
   output int                       words_seen,
   output int                       crcs_checked
);

   cfg_type             settings;
   logic [CrcWidth-1:0] running_crc;
   logic [CrcWidth-1:0] oldest_crc;
   logic [CrcWidth-1:0] crcs_due[$];
   int                  failures = 0;
   int                  word_total = 0;
   int                  crc_total = 0;

   assign fail_count   = failures;
   assign pending_crcs = crcs_due.size();
   assign words_seen   = word_total;
   assign crcs_checked = crc_total;

   function automatic logic [CrcWidth-1:0] start_crc(input cfg_type c);
      return c.wide ? c.init_sixteen : {8'h00, c.init_eight};
   endfunction

   function automatic logic [CrcWidth-1:0] fold_crc(input cfg_type c,
                                                    input logic [CrcWidth-1:0] crc,
                                                    input logic [ByteWidth-1:0] data);
      logic [CrcWidth-1:0] rev_poly;
      logic [CrcWidth-1:0] acc;
      rev_poly = '0;
      if (c.wide) begin
         for (int i = 0; i < 16; i++) rev_poly[15-i] = c.poly_sixteen[i];
      end else begin
         for (int i = 0; i < 8; i++) rev_poly[7-i] = c.poly_eight[i];
      end
      acc = c.wide ? crc : {8'h00, crc[7:0]};
      acc = acc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ rev_poly) : (acc >> 1);
      end
      if (!c.wide) begin
         acc[15:8] = 8'h00;
      end
      return acc;
   endfunction

   task automatic report_failure(input string what);
      if (failures < 10) begin
         $display("[%0t] %s", $realtime, what);
      end
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings = {WIDTH_MODE_RESET, POLY_SIXTEEN_RESET, INIT_SIXTEEN_RESET,
                     POLY_EIGHT_RESET, INIT_EIGHT_RESET};
         running_crc = INIT_SIXTEEN_RESET;
         crcs_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_WIDTH_MODE:   settings.wide         = csr_wdata[0];
               REG_POLY_SIXTEEN: settings.poly_sixteen = csr_wdata;
               REG_INIT_SIXTEEN: settings.init_sixteen = csr_wdata;
               REG_POLY_EIGHT:   settings.poly_eight   = csr_wdata[7:0];
               REG_INIT_EIGHT:   settings.init_eight   = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            word_total++;
            if (req_first_of_message) begin
               running_crc = start_crc(settings);
            end
            if (req_byte_present) begin
               running_crc = fold_crc(settings, running_crc, req_data_byte);
            end
            if (req_last_of_message) begin
               crcs_due.push_back(settings.wide ? running_crc : {8'h00, running_crc[7:0]});
               running_crc = start_crc(settings);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (crcs_due.size() == 0) begin
               report_failure($sformatf("CRC word %h returned with none due", rsp_crc_value));
            end else begin
               oldest_crc = crcs_due.pop_front();
               crc_total++;
               if (rsp_crc_value !== oldest_crc) begin
                  report_failure($sformatf("CRC mismatch: expected %h, got %h",
                                           oldest_crc, rsp_crc_value));
               end
            end
         end
      end
   end

endmodule

// ===== tb/reflected_crc_8_16_configurable_test.sv =====
// ----------------------------------------------------------------------------
// reflected_crc_8_16_configurable_test
// Drives the reflected CRC block with a short directed sequence and then
// random messages under several CRC settings in both widths, with sender and
// receiver idling in turn and one long output stall. A separate checker
// predicts every CRC word and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reflected_crc_8_16_configurable_test;
   import rcrc_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int ClockPeriod    = 8;
   localparam int ResetCycles    = 5;
   localparam int PhaseCount     = 8;
   localparam int PhaseWords     = 100;
   localparam int HoldPhase      = 4;
   localparam int LongHoldCycles = 200;
   localparam int SettleCycles   = 4;
   localparam int DrainCycles    = 8;
   localparam int CycleLimit     = 200000;
   localparam int IdlePercent    = 56;
   localparam int BothPercent    = 15;
   localparam logic [CsrIndexWidth-1:0] REG_SPARE_FIRST = REG_INIT_EIGHT + 1'b1;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;
   logic                     req_valid;
   logic                     req_ready;
   logic [ByteWidth-1:0]     req_data_byte;
   logic                     req_byte_present;
   logic                     req_first_of_message;
   logic                     req_last_of_message;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [CrcWidth-1:0]      rsp_crc_value;

   int            fail_count;
   int            pending_crcs;
   int            words_seen;
   int            crcs_checked;
   idle_mode_type idle_mode = IDLE_NONE;
   int            hold_requests = 0;
   int            words_left;
   int            cycle_count = 0;

   always #(ClockPeriod / 2) clock = ~clock;

   reflected_crc_8_16_configurable uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_byte_present     (req_byte_present),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_crc_value        (rsp_crc_value)
   );

   reflected_crc_8_16_configurable_crc_check crc_check (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_byte_present     (req_byte_present),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_crc_value        (rsp_crc_value),
      .fail_count           (fail_count),
      .pending_crcs         (pending_crcs),
      .words_seen           (words_seen),
      .crcs_checked         (crcs_checked)
   );

   function automatic bit draw_idle(input bit receiver_side);
      case (idle_mode)
         IDLE_SENDER:   return !receiver_side && ($urandom_range(99) < IdlePercent);
         IDLE_RECEIVER: return receiver_side && ($urandom_range(99) < IdlePercent);
         IDLE_BOTH:     return $urandom_range(99) < BothPercent;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic cfg_type phase_settings(input int phase);
      logic [31:0] r1;
      logic [31:0] r2;
      r1 = $urandom;
      r2 = $urandom;
      case (phase)
         0: return {WIDTH_MODE_RESET, POLY_SIXTEEN_RESET, INIT_SIXTEEN_RESET,
                    POLY_EIGHT_RESET, INIT_EIGHT_RESET};
         1: return {1'b0, 16'h8005, 16'h0000, 8'h07, 8'h00};
         2: return {1'b1, 16'h0000, 16'h0000, 8'h00, 8'h00};
         3: return {1'b0, 16'hffff, 16'hffff, 8'hff, 8'hff};
         4: return {1'b1, 16'hffff, 16'hffff, 8'hff, 8'hff};
         5: return {1'b0, r1[15:0], r1[31:16], r2[7:0], r2[15:8]};
         6: return {1'b1, r1[15:0], r1[31:16], r2[7:0], r2[15:8]};
         default: return {r2[16], r1[15:0], r1[31:16], r2[7:0], r2[15:8]};
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [ByteWidth-1:0] data, input logic present,
                            input logic first, input logic last);
      while (draw_idle(1'b0)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_data_byte        <= data;
      req_byte_present     <= present;
      req_first_of_message <= first;
      req_last_of_message  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly well-formed messages, with stray empty words, restarts and
   // messages left open
   task automatic send_message();
      int          len;
      logic [31:0] rnd;
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
         rnd = $urandom;
         if ($urandom_range(11) == 0) begin
            send_word(rnd[15:8], 1'b0, 1'b0, 1'b0);
         end
         send_word(rnd[7:0], $urandom_range(7) != 0,
                   (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(24) == 0),
                   (i == len - 1) && ($urandom_range(19) != 0));
         words_left--;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_crcs != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      logic [CsrIndexWidth-1:0] index_of[6];
      logic [CsrDataWidth-1:0]  word_of[6];
      logic [31:0]              r1;
      logic [31:0]              r2;
      r1 = $urandom;
      r2 = $urandom_range((1 << CsrIndexWidth) - 1, REG_SPARE_FIRST);
      index_of[0] = REG_WIDTH_MODE;
      index_of[1] = REG_POLY_SIXTEEN;
      index_of[2] = REG_INIT_SIXTEEN;
      index_of[3] = REG_POLY_EIGHT;
      index_of[4] = REG_INIT_EIGHT;
      index_of[5] = r2[CsrIndexWidth-1:0];
      word_of[0]  = {r1[15:1], c.wide};
      word_of[1]  = c.poly_sixteen;
      word_of[2]  = c.init_sixteen;
      word_of[3]  = {r1[23:16], c.poly_eight};
      word_of[4]  = {r1[31:24], c.init_eight};
      word_of[5]  = r1[31:16];
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= index_of[i];
         csr_wdata        <= word_of[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // output side: random stalls, plus one long hold-off on request
   initial begin
      int holds_served;
      holds_served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_ready <= 1'b0;
            repeat (LongHoldCycles) @(negedge clock);
         end else begin
            rsp_ready <= !draw_idle(1'b1);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d CRC words outstanding",
                  cycle_count, pending_crcs);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_valid            = 1'b0;
      req_data_byte        = '0;
      req_byte_present     = 1'b0;
      req_first_of_message = 1'b0;
      req_last_of_message  = 1'b0;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;

      // reset settings, 16-bit
      send_word(8'h00, 1'b0, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b1, 1'b0);
      send_word(8'hff, 1'b1, 1'b0, 1'b0);
      send_word(8'h55, 1'b1, 1'b0, 1'b0);
      send_word(8'haa, 1'b1, 1'b0, 1'b0);
      send_word(8'h12, 1'b0, 1'b0, 1'b0);
      send_word(8'h80, 1'b1, 1'b0, 1'b1);
      send_word(8'h01, 1'b1, 1'b0, 1'b0);
      send_word(8'hfe, 1'b1, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0, 1'b1);
      send_word(8'h3c, 1'b1, 1'b1, 1'b0);
      send_word(8'hc3, 1'b1, 1'b1, 1'b0);
      send_word(8'h7e, 1'b1, 1'b0, 1'b1);
      send_word(8'hff, 1'b1, 1'b1, 1'b1);
      // width switched to 8 bits with a message open
      send_word(8'ha5, 1'b1, 1'b1, 1'b0);
      wait_idle();
      apply_settings(phase_settings(3));
      send_word(8'h5a, 1'b1, 1'b0, 1'b1);
      send_word(8'h00, 1'b0, 1'b1, 1'b1);
      send_word(8'hc7, 1'b1, 1'b0, 1'b1);

      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_idle();
         apply_settings(phase_settings(phase));
         idle_mode <= idle_mode_type'(phase % 4);
         if (phase == HoldPhase) begin
            hold_requests <= hold_requests + 1;
         end
         words_left = PhaseWords;
         while (words_left > 0) send_message();
      end

      wait_idle();
      repeat (DrainCycles) @(negedge clock);

      $display("Covered %0d words over %0d CRC settings in both widths, with idling phases",
               words_seen, PhaseCount + 1);
      $display("and a long output hold-off; %0d CRC words compared.", crcs_checked);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
